// ----- rtl/core/srtf_pkg.sv -----
`default_nettype none
package srtf_pkg;

  localparam int ID_W    = 6;
  localparam int BURST_W = 16;
  localparam int TIME_W  = 32;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADM,
    S_SCAN,
    S_LAST,
    S_UPD,
    S_FIN
  } state_t;

  typedef enum logic [2:0] {
    STAT_IDLE     = 3'd0,
    STAT_RAN      = 3'd1,
    STAT_FINISHED = 3'd2,
    STAT_ADMITTED = 3'd3,
    STAT_REJECTED = 3'd4
  } status_t;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [BURST_W-1:0] burst;
    logic [BURST_W-1:0] executed;
    logic [TIME_W-1:0]  arrival;
    logic [TIME_W-1:0]  order;
  } entry_t;

  typedef struct packed {
    logic rd;
    logic wr;
    logic set_vld;
    logic clr_vld;
  } table_ctl_t;

endpackage
`default_nettype wire

// ----- rtl/core/srtf_tick_scheduler.sv -----
// admit: one free-slot probe a cycle from slot 0, strobing ADMITTED at the first free slot or REJECTED after the last
// tick: states scan, last compare and update, plus a finish state on completion; the scan reads
//   one table entry a cycle through the single memory port
// one item at a time: busy stays high until the result is registered
// results are strobed for one cycle and the receiver cannot stall them
// synchronous reset clears valid bits, clock and admit counter; no clearing pass
`default_nettype none
module srtf_tick_scheduler import srtf_pkg::*; #(
  parameter int TABLE_DEPTH = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               in_action,
  input  wire logic [ID_W-1:0]    in_process_id,
  input  wire logic [BURST_W-1:0] in_burst_length,
  output logic                    out_valid,
  output logic [2:0]              out_status,
  output logic [ID_W-1:0]         out_running_id,
  output logic [TIME_W-1:0]       out_turnaround,
  output logic [TIME_W-1:0]       out_waiting
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);

  table_ctl_t       tbl_ctl;
  logic [IDX_W-1:0] tbl_addr;
  entry_t           tbl_wdata;
  entry_t           tbl_rdata;
  logic             tbl_rd_vld;
  logic             tbl_addr_vld;

  srtf_ctrl #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_action      (in_action),
    .in_process_id  (in_process_id),
    .in_burst_length(in_burst_length),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_running_id (out_running_id),
    .out_turnaround (out_turnaround),
    .out_waiting    (out_waiting),
    .tbl_ctl        (tbl_ctl),
    .tbl_addr       (tbl_addr),
    .tbl_wdata      (tbl_wdata),
    .tbl_rdata      (tbl_rdata),
    .tbl_rd_vld     (tbl_rd_vld),
    .tbl_addr_vld   (tbl_addr_vld)
  );

  srtf_table #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (tbl_ctl),
    .addr    (tbl_addr),
    .wdata   (tbl_wdata),
    .rdata   (tbl_rdata),
    .rd_vld  (tbl_rd_vld),
    .addr_vld(tbl_addr_vld)
  );

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after input transfer");

  a_strobe_when_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobed while item still in progress");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  a_times_only_on_finish: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != STAT_FINISHED)) |->
      ((out_turnaround == '0) && (out_waiting == '0)))
    else $error("timing fields nonzero on a result that is not a completion");

endmodule
`default_nettype wire

// ----- rtl/core/srtf_table.sv -----
`default_nettype none
module srtf_table import srtf_pkg::*; #(
  parameter int TABLE_DEPTH = 16,
  localparam int IDX_W = $clog2(TABLE_DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire table_ctl_t       ctl,
  input  wire logic [IDX_W-1:0] addr,
  input  wire entry_t           wdata,
  output entry_t                rdata,
  output logic                  rd_vld,
  output logic                  addr_vld
);

  entry_t                   mem_r [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0]   vld_r;
  entry_t                   rdata_r;
  logic                     rd_vld_r;

  // single address port: one read and one write per cycle, both at the same address
  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      mem_r[addr] <= wdata;
    end
    if (ctl.rd) begin
      rdata_r  <= mem_r[addr];
      rd_vld_r <= vld_r[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ctl.set_vld) begin
      vld_r[addr] <= 1'b1;
    end else if (ctl.clr_vld) begin
      vld_r[addr] <= 1'b0;
    end
  end

  assign rdata    = rdata_r;
  assign rd_vld   = rd_vld_r;
  assign addr_vld = vld_r[addr];

endmodule
`default_nettype wire

// ----- rtl/core/srtf_ctrl.sv -----
`default_nettype none
module srtf_ctrl import srtf_pkg::*; #(
  parameter int TABLE_DEPTH = 16,
  localparam int IDX_W = $clog2(TABLE_DEPTH)
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               in_action,
  input  wire logic [ID_W-1:0]    in_process_id,
  input  wire logic [BURST_W-1:0] in_burst_length,
  output logic                    out_valid,
  output logic [2:0]              out_status,
  output logic [ID_W-1:0]         out_running_id,
  output logic [TIME_W-1:0]       out_turnaround,
  output logic [TIME_W-1:0]       out_waiting,
  output table_ctl_t              tbl_ctl,
  output logic [IDX_W-1:0]        tbl_addr,
  output entry_t                  tbl_wdata,
  input  wire entry_t             tbl_rdata,
  input  wire logic               tbl_rd_vld,
  input  wire logic               tbl_addr_vld
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

  state_t             state_r, state_nxt;
  logic [IDX_W-1:0]   cnt_r, cnt_nxt;
  logic [ID_W-1:0]    pid_r, pid_nxt;
  logic [BURST_W-1:0] burst_r, burst_nxt;
  logic [TIME_W-1:0]  clock_r, clock_nxt;
  logic [TIME_W-1:0]  admit_cnt_r, admit_cnt_nxt;
  logic               cmp_en_r, cmp_en_nxt;
  logic [IDX_W-1:0]   cmp_idx_r, cmp_idx_nxt;
  logic               found_r, found_nxt;
  logic [IDX_W-1:0]   best_idx_r, best_idx_nxt;
  logic [BURST_W-1:0] best_rem_r, best_rem_nxt;
  entry_t             best_r, best_nxt;
  logic [TIME_W-1:0]  turn_r, turn_nxt;

  logic               out_vld_r, out_vld_nxt;
  status_t            out_status_r, out_status_nxt;
  logic [ID_W-1:0]    out_id_r, out_id_nxt;
  logic [TIME_W-1:0]  out_turn_r, out_turn_nxt;
  logic [TIME_W-1:0]  out_wait_r, out_wait_nxt;

  logic [BURST_W-1:0] rem_cand;
  logic               better;
  logic [BURST_W-1:0] exec_inc;
  logic               fin;

  // candidate from the entry read last cycle
  assign rem_cand = (tbl_rdata.executed >= tbl_rdata.burst) ? '0 :
                    tbl_rdata.burst - tbl_rdata.executed;
  assign better   = !found_r || (rem_cand < best_rem_r) ||
                    ((rem_cand == best_rem_r) && (tbl_rdata.order < best_r.order));

  // executed count saturates at all ones
  assign exec_inc = (best_r.executed == '1) ? best_r.executed :
                    best_r.executed + BURST_W'(1);
  assign fin      = exec_inc >= best_r.burst;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = in_action ? S_SCAN : S_ADM;
        end
      end
      S_ADM: begin
        if (!tbl_addr_vld || (cnt_r == LAST_IDX)) begin
          state_nxt = S_IDLE;
        end
      end
      S_SCAN: begin
        if (cnt_r == LAST_IDX) begin
          state_nxt = S_LAST;
        end
      end
      S_LAST: state_nxt = S_UPD;
      S_UPD:  state_nxt = (found_r && fin) ? S_FIN : S_IDLE;
      S_FIN:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cnt_nxt        = cnt_r;
    pid_nxt        = pid_r;
    burst_nxt      = burst_r;
    clock_nxt      = clock_r;
    admit_cnt_nxt  = admit_cnt_r;
    cmp_en_nxt     = 1'b0;
    cmp_idx_nxt    = cmp_idx_r;
    found_nxt      = found_r;
    best_idx_nxt   = best_idx_r;
    best_rem_nxt   = best_rem_r;
    best_nxt       = best_r;
    turn_nxt       = turn_r;
    out_vld_nxt    = 1'b0;
    out_status_nxt = out_status_r;
    out_id_nxt     = out_id_r;
    out_turn_nxt   = out_turn_r;
    out_wait_nxt   = out_wait_r;
    tbl_ctl        = '0;
    tbl_addr       = cnt_r;
    tbl_wdata      = best_r;
    tbl_wdata.executed = exec_inc;

    if (cmp_en_r && tbl_rd_vld && better) begin
      found_nxt    = 1'b1;
      best_idx_nxt = cmp_idx_r;
      best_rem_nxt = rem_cand;
      best_nxt     = tbl_rdata;
    end

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cnt_nxt   = '0;
          pid_nxt   = in_process_id;
          burst_nxt = in_burst_length;
          found_nxt = 1'b0;
        end
      end
      S_ADM: begin
        out_id_nxt   = pid_r;
        out_turn_nxt = '0;
        out_wait_nxt = '0;
        if (!tbl_addr_vld) begin
          tbl_ctl.wr         = 1'b1;
          tbl_ctl.set_vld    = 1'b1;
          tbl_wdata.id       = pid_r;
          tbl_wdata.burst    = burst_r;
          tbl_wdata.executed = '0;
          tbl_wdata.arrival  = clock_r;
          tbl_wdata.order    = admit_cnt_r;
          admit_cnt_nxt      = admit_cnt_r + TIME_W'(1);
          out_vld_nxt        = 1'b1;
          out_status_nxt     = STAT_ADMITTED;
        end else if (cnt_r == LAST_IDX) begin
          out_vld_nxt    = 1'b1;
          out_status_nxt = STAT_REJECTED;
        end else begin
          cnt_nxt = cnt_r + IDX_W'(1);
        end
      end
      S_SCAN: begin
        tbl_ctl.rd  = 1'b1;
        cmp_en_nxt  = 1'b1;
        cmp_idx_nxt = cnt_r;
        cnt_nxt     = cnt_r + IDX_W'(1);
      end
      S_LAST: begin
      end
      S_UPD: begin
        clock_nxt    = clock_r + TIME_W'(1);
        tbl_addr     = best_idx_r;
        out_turn_nxt = '0;
        out_wait_nxt = '0;
        if (found_r) begin
          tbl_ctl.wr      = 1'b1;
          tbl_ctl.clr_vld = fin;
          if (fin) begin
            turn_nxt = clock_r - best_r.arrival + TIME_W'(1);
          end else begin
            out_vld_nxt    = 1'b1;
            out_status_nxt = STAT_RAN;
            out_id_nxt     = best_r.id;
          end
        end else begin
          out_vld_nxt    = 1'b1;
          out_status_nxt = STAT_IDLE;
          out_id_nxt     = '0;
        end
      end
      S_FIN: begin
        out_vld_nxt    = 1'b1;
        out_status_nxt = STAT_FINISHED;
        out_id_nxt     = best_r.id;
        out_turn_nxt   = turn_r;
        out_wait_nxt   = turn_r - TIME_W'(best_r.burst);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      clock_r     <= '0;
      admit_cnt_r <= '0;
      cmp_en_r    <= 1'b0;
      found_r     <= 1'b0;
      out_vld_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clock_r     <= clock_nxt;
      admit_cnt_r <= admit_cnt_nxt;
      cmp_en_r    <= cmp_en_nxt;
      found_r     <= found_nxt;
      out_vld_r   <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r        <= cnt_nxt;
    pid_r        <= pid_nxt;
    burst_r      <= burst_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    best_idx_r   <= best_idx_nxt;
    best_rem_r   <= best_rem_nxt;
    best_r       <= best_nxt;
    turn_r       <= turn_nxt;
    out_status_r <= out_status_nxt;
    out_id_r     <= out_id_nxt;
    out_turn_r   <= out_turn_nxt;
    out_wait_r   <= out_wait_nxt;
  end

  assign busy           = (state_r != S_IDLE);
  assign out_valid      = out_vld_r;
  assign out_status     = out_status_r;
  assign out_running_id = out_id_r;
  assign out_turnaround = out_turn_r;
  assign out_waiting    = out_wait_r;

endmodule
`default_nettype wire

// ----- sim/tb.sv -----
`timescale 1ns / 100ps
module tb;
  import srtf_pkg::*;

  localparam int DEPTH = 16;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 2 * DEPTH + 8;
  localparam int MAX_REPORTS = 200;
  localparam int PHASE_ITEMS = 170;
  localparam bit ACT_ADMIT = 1'b0;
  localparam bit ACT_TICK = 1'b1;

  typedef struct packed {
    status_t             st;
    logic [ID_W-1:0]     id;
    logic [TIME_W-1:0]   turn;
    logic [TIME_W-1:0]   waited;
  } outcome_t;

  typedef struct packed {
    logic                act;
    logic [ID_W-1:0]     pid;
    logic [BURST_W-1:0]  burst;
    logic                typed;
    outcome_t            res;
  } job_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic in_action = 1'b0;
  logic [ID_W-1:0] in_process_id = '0;
  logic [BURST_W-1:0] in_burst_length = '0;
  logic busy;
  logic out_valid;
  logic [2:0] out_status;
  logic [ID_W-1:0] out_running_id;
  logic [TIME_W-1:0] out_turnaround;
  logic [TIME_W-1:0] out_waiting;

  srtf_tick_scheduler #(.TABLE_DEPTH(DEPTH)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_action(in_action),
    .in_process_id(in_process_id),
    .in_burst_length(in_burst_length),
    .out_valid(out_valid),
    .out_status(out_status),
    .out_running_id(out_running_id),
    .out_turnaround(out_turnaround),
    .out_waiting(out_waiting)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow copy of the process table
  logic                slot_used [DEPTH];
  logic [ID_W-1:0]     slot_pid [DEPTH];
  logic [BURST_W-1:0]  slot_burst [DEPTH];
  logic [BURST_W-1:0]  slot_ran [DEPTH];
  logic [TIME_W-1:0]   slot_arrival [DEPTH];
  logic [TIME_W-1:0]   slot_seq [DEPTH];
  logic [TIME_W-1:0]   now_tick = '0;
  logic [TIME_W-1:0]   admit_seq = '0;

  outcome_t pending_outcomes [$];
  job_row_t issued_rows [$];
  job_row_t plan_rows [$];

  int errors = 0;
  int items_taken = 0;
  int quiet_cycles = 0;
  int n_admit = 0, n_reject = 0, n_ran = 0, n_finish = 0, n_idle = 0;
  int sender_idle_pct = 0;

  initial begin
    for (int i = 0; i < DEPTH; i++) slot_used[i] = 1'b0;
  end

  function automatic outcome_t srtf_predict(logic act, logic [ID_W-1:0] pid,
                                            logic [BURST_W-1:0] bl);
    outcome_t r;
    int free_slot, best;
    logic [BURST_W-1:0] rem, best_rem;
    logic [BURST_W:0] ran_next;
    r.st = STAT_IDLE;
    r.id = '0;
    r.turn = '0;
    r.waited = '0;
    best_rem = '0;
    if (act == ACT_ADMIT) begin
      free_slot = -1;
      for (int i = DEPTH - 1; i >= 0; i--) if (!slot_used[i]) free_slot = i;
      r.id = pid;
      if (free_slot < 0) begin
        r.st = STAT_REJECTED;
      end else begin
        slot_used[free_slot] = 1'b1;
        slot_pid[free_slot] = pid;
        slot_burst[free_slot] = bl;
        slot_ran[free_slot] = '0;
        slot_arrival[free_slot] = now_tick;
        slot_seq[free_slot] = admit_seq;
        admit_seq = admit_seq + 1;
        r.st = STAT_ADMITTED;
      end
    end else begin
      best = -1;
      for (int i = 0; i < DEPTH; i++) begin
        if (slot_used[i]) begin
          rem = (slot_ran[i] >= slot_burst[i]) ? '0 : slot_burst[i] - slot_ran[i];
          if (best < 0 || rem < best_rem ||
              (rem == best_rem && slot_seq[i] < slot_seq[best])) begin
            best = i;
            best_rem = rem;
          end
        end
      end
      if (best >= 0) begin
        // executed count saturates at the top of its range
        ran_next = {1'b0, slot_ran[best]} + 1'b1;
        if (ran_next[BURST_W]) ran_next = {1'b0, {BURST_W{1'b1}}};
        slot_ran[best] = ran_next[BURST_W-1:0];
        r.id = slot_pid[best];
        if (ran_next[BURST_W-1:0] >= slot_burst[best]) begin
          r.st = STAT_FINISHED;
          r.turn = now_tick - slot_arrival[best] + 1;
          r.waited = r.turn - TIME_W'(slot_burst[best]);
          slot_used[best] = 1'b0;
        end else begin
          r.st = STAT_RAN;
        end
      end
      now_tick = now_tick + 1;
    end
    return r;
  endfunction

  function automatic job_row_t mk_row(logic act, logic [ID_W-1:0] pid,
                                      logic [BURST_W-1:0] bl, logic typed,
                                      status_t st, logic [ID_W-1:0] id,
                                      logic [TIME_W-1:0] turn,
                                      logic [TIME_W-1:0] waited);
    job_row_t r;
    r.act = act;
    r.pid = pid;
    r.burst = bl;
    r.typed = typed;
    r.res.st = st;
    r.res.id = id;
    r.res.turn = turn;
    r.res.waited = waited;
    return r;
  endfunction

  function automatic void add_plan_row(job_row_t r);
    plan_rows.insert(plan_rows.size(), r);
  endfunction

  // long jobs (burst above 255) may not finish in this run, so new ones are drawn only while fewer than 3 are resident
  function automatic logic [BURST_W-1:0] pick_burst();
    int long_live;
    int sel;
    long_live = 0;
    for (int i = 0; i < DEPTH; i++) if (slot_used[i] && slot_burst[i] > 255) long_live++;
    sel = $urandom_range(99);
    if (sel < 5) return '0;
    if (sel < 10 && long_live < 3) return BURST_W'($urandom);
    if (sel < 25) return BURST_W'($urandom_range(7, 40));
    return BURST_W'($urandom_range(1, 6));
  endfunction

  task automatic issue(input job_row_t row);
    int gap;
    gap = 0;
    while (gap < 60 && $urandom_range(99) < sender_idle_pct) gap++;
    if (sender_idle_pct != 0 && $urandom_range(7) == 0) gap += $urandom_range(24);
    issued_rows.insert(issued_rows.size(), row);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_action <= row.act;
    in_process_id <= row.pid;
    in_burst_length <= row.burst;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // result check first, then the transfer on the input side
  always @(posedge clk) begin
    outcome_t got, want, pred;
    job_row_t row;
    if (rst_n) begin
      if (out_valid) begin
        got.st = status_t'(out_status);
        got.id = out_running_id;
        got.turn = out_turnaround;
        got.waited = out_waiting;
        if (pending_outcomes.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: unexpected result status %0d id %0d", $time, out_status,
                     out_running_id);
        end else begin
          want = pending_outcomes.pop_front();
          if (got.st !== want.st) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("%0t: status mismatch exp %0d got %0d", $time, want.st, out_status);
          end
          if (got.id !== want.id) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("%0t: running_id mismatch exp %0d got %0d", $time, want.id, got.id);
          end
          if (got.turn !== want.turn) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("%0t: turnaround mismatch exp %0d got %0d", $time, want.turn,
                       got.turn);
          end
          if (got.waited !== want.waited) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("%0t: waiting mismatch exp %0d got %0d", $time, want.waited,
                       got.waited);
          end
        end
      end
      if (start && !busy) begin
        pred = srtf_predict(in_action, in_process_id, in_burst_length);
        row = issued_rows.pop_front();
        pending_outcomes.insert(pending_outcomes.size(), row.typed ? row.res : pred);
        case (pred.st)
          STAT_ADMITTED: n_admit++;
          STAT_REJECTED: n_reject++;
          STAT_RAN: n_ran++;
          STAT_FINISHED: n_finish++;
          default: n_idle++;
        endcase
        items_taken++;
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
          $display("DONE: errors detected");
          $finish;
        end
      end
    end
  end

  initial begin
    job_row_t row;
    int admit_pct;
    int pause_at;
    int sel;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty tick, zero burst, long job, fill to full, reject when full, then ticks over tied bursts
    add_plan_row(mk_row(ACT_TICK, 6'd0, 16'd0, 1'b1, STAT_IDLE, 6'd0, 0, 0));
    add_plan_row(mk_row(ACT_ADMIT, 6'd63, 16'd0, 1'b1, STAT_ADMITTED, 6'd63, 0, 0));
    add_plan_row(mk_row(ACT_TICK, 6'd0, 16'd0, 1'b1, STAT_FINISHED, 6'd63, 1, 1));
    add_plan_row(mk_row(ACT_ADMIT, 6'd0, 16'hFFFF, 1'b1, STAT_ADMITTED, 6'd0, 0, 0));
    for (int k = 1; k < DEPTH; k++)
      add_plan_row(mk_row(ACT_ADMIT, ID_W'(4 * k + 1), BURST_W'(k % 4 + 1), 1'b1,
                          STAT_ADMITTED, ID_W'(4 * k + 1), 0, 0));
    add_plan_row(mk_row(ACT_ADMIT, 6'd33, 16'd7, 1'b1, STAT_REJECTED, 6'd33, 0, 0));
    for (int k = 0; k < 5; k++)
      add_plan_row(mk_row(ACT_TICK, ID_W'($urandom), BURST_W'($urandom), 1'b0,
                          STAT_IDLE, 6'd0, 0, 0));
    foreach (plan_rows[n]) issue(plan_rows[n]);

    admit_pct = 50;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: sender_idle_pct = 0;
        1: sender_idle_pct = 52;
        2: sender_idle_pct = 0;
        default: sender_idle_pct = 38;
      endcase
      pause_at = $urandom_range(20, PHASE_ITEMS - 20);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 40 == 0) begin
          sel = $urandom_range(2);
          admit_pct = (sel == 0) ? 25 : (sel == 1) ? 50 : 80;
        end
        if (n == pause_at) begin
          // hold off until the block has answered everything
          start <= 1'b0;
          do @(posedge clk); while (pending_outcomes.size() != 0);
        end
        row.act = ($urandom_range(99) < admit_pct) ? ACT_ADMIT : ACT_TICK;
        row.pid = ID_W'($urandom);
        row.burst = (row.act == ACT_ADMIT) ? pick_burst() : BURST_W'($urandom);
        row.typed = 1'b0;
        row.res = '0;
        issue(row);
      end
    end

    start <= 1'b0;
    do @(posedge clk); while (pending_outcomes.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("ran %0d transfers: %0d admitted, %0d rejected as full", items_taken, n_admit,
             n_reject);
    $display("ticks: %0d ran, %0d finished, %0d idle", n_ran, n_finish, n_idle);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
